/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the core RTL.
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OWBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next clock.
`define OWBM_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* rtl/core/owbm_pkg.sv */
package owbm_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 10;
    localparam int IDX_W    = 3;

    // Command codes carried in func
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    // Sequence phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_TAIL  = 4'd3,
        PH_WR_FIRST  = 4'd4,
        PH_WR_SECOND = 4'd5,
        PH_RD_LOW    = 4'd6,
        PH_RD_WAIT   = 4'd7,
        PH_RD_TAIL   = 4'd8
    } phase_t;

    // Timing register indexes
    localparam logic [IDX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESET_TAIL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOT_LONG    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SLOT_SHORT   = 3'd4;
    localparam logic [IDX_W-1:0] REG_READ_LOW     = 3'd5;
    localparam logic [IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [IDX_W-1:0] REG_READ_TAIL    = 3'd7;

    typedef logic [REG_W-1:0] timing_t;

    localparam timing_t REG_RESET_VALS [NUM_REGS] = '{
        10'd480, 10'd70, 10'd410, 10'd65, 10'd10, 10'd5, 10'd5, 10'd55
    };

    localparam logic [2:0] LAST_BIT       = 3'd7;
    localparam logic [1:0] PRESENCE_SCORE = 2'd2;

endpackage

/* rtl/core/owbm_cmd_if.sv */
interface owbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] wr_byte;
    logic       line_in;

    modport source (output valid, output func, output wr_byte, output line_in, input ready);
    modport sink   (input valid, input func, input wr_byte, input line_in, output ready);
endinterface

/* rtl/core/owbm_res_if.sv */
interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rd_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output rd_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input rd_byte, output ready);
endinterface

/* rtl/core/one_wire_bus_master.sv */
// Channel   | Dir | Payload                                        | Handshake
// cmd       | in  | func, wr_byte, line_in                         | valid/ready
// result    | out | drive_low, busy_res, done_res, presence, rd_byte | valid/ready
// cfg       | in  | cfg_index, cfg_data                            | cfg_we only
//
// Each command or tick transaction yields one result, registered in the cycle after acceptance.
// Throughput is one transaction per cycle while result.ready stays high, set by the single result register.
// cmd.ready drops only while a result is held and result.ready is low.
// Reset puts the sequencer in idle, releases the bus and loads default timings.
module one_wire_bus_master #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owbm_pkg::IDX_W-1:0]        cfg_index,
    input  logic [owbm_pkg::REG_W-1:0]        cfg_data,
    owbm_cmd_if.sink                          cmd,
    owbm_res_if.source                        result
);
    import owbm_pkg::*;

    `include "assert_macros.svh"

    timing_t                cfg_reg [NUM_REGS];
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic [1:0]             score_reg, score_next;
    logic                   drive_reg, drive_next;

    logic                   res_valid_reg;
    logic                   res_drive_reg, res_busy_reg, res_done_reg, res_pres_reg;
    logic [7:0]             res_rd_reg;

    logic                   cmd_fire;
    logic                   cur_bit;
    timing_t                len_sel;
    logic [COUNT_WIDTH-1:0] len;
    logic                   done_c, pres_c;
    logic [7:0]             rd_c;

    assign cmd.ready = !res_valid_reg || result.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cur_bit   = shift_reg[bit_reg];

    // Store timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET_VALS[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Select the duration of the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:   len_sel = cfg_reg[REG_RESET_LOW];
            PH_RST_WAIT:  len_sel = cfg_reg[REG_PRES_WAIT];
            PH_RST_TAIL:  len_sel = cfg_reg[REG_RESET_TAIL];
            PH_WR_FIRST:  len_sel = cur_bit ? cfg_reg[REG_SLOT_SHORT] : cfg_reg[REG_SLOT_LONG];
            PH_WR_SECOND: len_sel = cur_bit ? cfg_reg[REG_SLOT_LONG] : cfg_reg[REG_SLOT_SHORT];
            PH_RD_LOW:    len_sel = cfg_reg[REG_READ_LOW];
            PH_RD_WAIT:   len_sel = cfg_reg[REG_READ_SAMPLE];
            PH_RD_TAIL:   len_sel = cfg_reg[REG_READ_TAIL];
            default:      len_sel = '0;
        endcase
    end

    // Durations wrap to the counter width
    assign len = COUNT_WIDTH'(len_sel);

    // Advance the sequencer on each accepted transaction
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        score_next = score_reg;
        drive_next = drive_reg;
        done_c     = 1'b0;
        pres_c     = 1'b0;
        rd_c       = '0;
        if (cmd_fire)
        begin
            if (func_t'(cmd.func) != FUNC_TICK)
            begin
                // Start a sequence only from idle; drop commands while busy
                if (phase_reg == PH_IDLE)
                begin
                    tick_next  = '0;
                    bit_next   = '0;
                    score_next = '0;
                    drive_next = 1'b1;
                    unique case (func_t'(cmd.func))
                        FUNC_RESET:
                        begin
                            phase_next = PH_RST_LOW;
                            shift_next = '0;
                        end
                        FUNC_WRITE:
                        begin
                            phase_next = PH_WR_FIRST;
                            shift_next = cmd.wr_byte;
                        end
                        default:
                        begin
                            phase_next = PH_RD_LOW;
                            shift_next = '0;
                        end
                    endcase
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (tick_reg != len)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                else
                begin
                    tick_next = '0;
                    unique case (phase_reg)
                        PH_RST_LOW:
                        begin
                            drive_next = 1'b0;
                            phase_next = PH_RST_WAIT;
                        end
                        PH_RST_WAIT:
                        begin
                            if (!cmd.line_in)
                            begin
                                score_next = score_reg + 1'b1;
                            end
                            phase_next = PH_RST_TAIL;
                        end
                        PH_RST_TAIL:
                        begin
                            if (cmd.line_in)
                            begin
                                score_next = score_reg + 1'b1;
                            end
                            done_c     = 1'b1;
                            pres_c     = (score_next == PRESENCE_SCORE);
                            phase_next = PH_IDLE;
                        end
                        PH_WR_FIRST:
                        begin
                            drive_next = 1'b0;
                            phase_next = PH_WR_SECOND;
                        end
                        PH_WR_SECOND:
                        begin
                            if (bit_reg == LAST_BIT)
                            begin
                                done_c     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 1'b1;
                                drive_next = 1'b1;
                                phase_next = PH_WR_FIRST;
                            end
                        end
                        PH_RD_LOW:
                        begin
                            drive_next = 1'b0;
                            phase_next = PH_RD_WAIT;
                        end
                        PH_RD_WAIT:
                        begin
                            if (cmd.line_in)
                            begin
                                shift_next[bit_reg] = 1'b1;
                            end
                            phase_next = PH_RD_TAIL;
                        end
                        PH_RD_TAIL:
                        begin
                            if (bit_reg == LAST_BIT)
                            begin
                                done_c     = 1'b1;
                                rd_c       = shift_reg;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 1'b1;
                                drive_next = 1'b1;
                                phase_next = PH_RD_LOW;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                    // Release the bus whenever the sequence ends
                    if (phase_next == PH_IDLE)
                    begin
                        drive_next = 1'b0;
                    end
                end
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            score_reg <= '0;
            drive_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            score_reg <= score_next;
            drive_reg <= drive_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Load result payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_drive_reg <= drive_next;
            res_busy_reg  <= (phase_next != PH_IDLE);
            res_done_reg  <= done_c;
            res_pres_reg  <= pres_c;
            res_rd_reg    <= rd_c;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.drive_low = res_drive_reg;
    assign result.busy_res  = res_busy_reg;
    assign result.done_res  = res_done_reg;
    assign result.presence  = res_pres_reg;
    assign result.rd_byte   = res_rd_reg;

    `OWBM_ASSERT(a_idle_released, (phase_reg != PH_IDLE) || (!drive_reg && tick_reg == '0), "bus driven or counter running while idle")
    `OWBM_ASSERT(a_done_released, !(result.valid && result.done_res) || (!result.busy_res && !result.drive_low), "done result still busy or driving")
    `OWBM_ASSERT_NEXT(a_start_busy, cmd_fire && phase_reg == PH_IDLE && cmd.func != FUNC_TICK, phase_reg != PH_IDLE && drive_reg, "command from idle did not start a sequence")
    `OWBM_ASSERT_NEXT(a_result_follows, cmd_fire, result.valid, "accepted transaction produced no result")

endmodule
